FILE: sv/lef_pkg.sv
// Shared constants, types and helpers for the RGB Laplacian edge filter.
// No dependencies; the top level, lef_calc, lef_out_fifo and lef_checker import it.
package lef_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;

    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int WID_W     = $clog2(MAX_WIDTH + 1);
    localparam int ROW_W     = $clog2(MAX_HEIGHT + 1);
    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 1;
    localparam int CH_W      = 8;

    localparam int OUT_DEPTH = 3;
    localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
    localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = CFG_IDX_W'(1);

    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_FLUSH = 1'b1;

    localparam logic [WID_W-1:0] WIDTH_RESET  = WID_W'(800);
    localparam logic [ROW_W-1:0] HEIGHT_RESET = ROW_W'(600);

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } t_pixel;

    // One line RAM word: the pixel two rows up and the pixel one row up.
    typedef struct packed {
        t_pixel above;
        t_pixel centre;
    } t_line_entry;

    localparam int LINE_W = $bits(t_line_entry);

    typedef struct packed {
        t_pixel pix;
        logic   frame_end;
    } t_result;

    function automatic logic [WID_W-1:0] clamp_width(input logic [CFG_W-1:0] v);
        logic [WID_W-1:0] w;
        if (v == '0) begin
            w = WID_W'(1);
        end else if (int'(v) > MAX_WIDTH) begin
            w = WID_W'(MAX_WIDTH);
        end else begin
            w = WID_W'(v);
        end
        return w;
    endfunction

    function automatic logic [ROW_W-1:0] clamp_height(input logic [CFG_W-1:0] v);
        logic [ROW_W-1:0] h;
        if (v == '0) begin
            h = ROW_W'(1);
        end else if (int'(v) > MAX_HEIGHT) begin
            h = ROW_W'(MAX_HEIGHT);
        end else begin
            h = ROW_W'(v);
        end
        return h;
    endfunction

endpackage

FILE: sv/laplacian_edge_filter_rgb_top.sv
// RGB Laplacian edge filter, top level: counters, line RAM access, forwarding.
// Depends on lef_pkg, lef_line_ram, lef_calc and lef_out_fifo.
//
// Takes one pixel beat per clock while o_in_ready is high, in raster order, and
// returns, per channel, up + down + left + right - 4 * centre clamped to
// 0..255, with neighbours outside the frame read as zero. Results lag the input
// by one row: row 0 produces nothing, every later pixel releases the result of
// the pixel above it, and after the last pixel one flush beat per column drains
// the final row (frame_end marks its last result). Flush beats before the frame
// is complete are dropped without a result. Sustained rate is one beat per clock
// while the output queue has room; each beat does one read and one write of a
// single line RAM (1024 x 48 bits, the two previous rows of a column in one
// word), so that RAM port pair sets the rate. A small output queue keeps input
// running while the consumer stalls briefly. The line RAM needs no clearing
// after reset. Register writes restart the frame.
module laplacian_edge_filter_rgb_top
    import lef_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic                 i_command,
    input  logic [CH_W-1:0]      i_in_red,
    input  logic [CH_W-1:0]      i_in_green,
    input  logic [CH_W-1:0]      i_in_blue,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [CH_W-1:0]      o_out_red,
    output logic [CH_W-1:0]      o_out_green,
    output logic [CH_W-1:0]      o_out_blue,
    output logic                 o_frame_end
);

    typedef struct packed {
        logic             valid;
        logic             emit;
        logic             above_en;
        logic             right_en;
        logic             frame_end;
        logic             self_fwd;
        logic             fwd;
        logic [COL_W-1:0] col;
        t_pixel           below;
    } t_s1_ctrl;

    logic [WID_W-1:0] r_width;
    logic [ROW_W-1:0] r_height;
    logic [COL_W-1:0] r_col;
    logic [ROW_W-1:0] r_row;
    t_pixel           r_left;
    t_line_entry      r_cur;
    t_line_entry      r_fwd_data;
    t_s1_ctrl         r_s1;
    t_s1_ctrl         n_s1;

    logic             in_beat;
    logic             flushing;
    logic             take;
    logic             last_col;
    logic [COL_W-1:0] rd_addr;
    t_pixel           in_pix;

    t_line_entry      ram_rdata;
    t_line_entry      rd_entry;
    t_line_entry      wr_entry;
    t_pixel           right_pix;
    t_pixel           above_pix;
    t_pixel           lap_pix;
    t_result          push_data;
    logic             push;
    logic [OUT_CNT_W-1:0] out_count;
    t_result          out_data;

    // ---------------- stage 0: accept, column/row bookkeeping, RAM read
    assign in_beat  = i_in_valid & o_in_ready;
    assign flushing = (r_row >= r_height);
    assign take     = in_beat & (flushing | (i_command == CMD_PIXEL));
    assign last_col = ((WID_W'(r_col) + WID_W'(1)) == r_width);
    // last column prefetches column 0 for the next row
    assign rd_addr  = last_col ? '0 : r_col + COL_W'(1);

    assign in_pix.red   = i_in_red;
    assign in_pix.green = i_in_green;
    assign in_pix.blue  = i_in_blue;

    always_comb begin
        n_s1           = r_s1;
        n_s1.valid     = take;
        n_s1.emit      = (r_row != '0);
        n_s1.above_en  = (r_row >= ROW_W'(2));
        n_s1.right_en  = !last_col;
        n_s1.frame_end = flushing & last_col;
        n_s1.self_fwd  = last_col & (r_col == '0);
        n_s1.fwd       = r_s1.valid & (rd_addr == r_s1.col);
        n_s1.col       = r_col;
        n_s1.below     = flushing ? '0 : in_pix;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WIDTH_RESET;
            r_height <= HEIGHT_RESET;
            r_col    <= '0;
            r_row    <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_IMAGE_WIDTH:  r_width  <= clamp_width(i_cfg_data);
                REG_IMAGE_HEIGHT: r_height <= clamp_height(i_cfg_data);
                default:          r_width  <= r_width;
            endcase
            r_col <= '0;
            r_row <= '0;
        end else if (take) begin
            if (last_col) begin
                r_col <= '0;
                r_row <= flushing ? '0 : r_row + ROW_W'(1);
            end else begin
                r_col <= r_col + COL_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1.valid <= 1'b0;
        end else begin
            r_s1.valid <= n_s1.valid;
        end
        r_s1.emit      <= n_s1.emit;
        r_s1.above_en  <= n_s1.above_en;
        r_s1.right_en  <= n_s1.right_en;
        r_s1.frame_end <= n_s1.frame_end;
        r_s1.self_fwd  <= n_s1.self_fwd;
        r_s1.fwd       <= n_s1.fwd;
        r_s1.col       <= n_s1.col;
        r_s1.below     <= n_s1.below;
        // stage 1 write this cycle lands after the read: keep it for bypass
        r_fwd_data     <= wr_entry;
    end

    lef_line_ram #(
        .DATA_W (LINE_W),
        .DEPTH  (MAX_WIDTH),
        .ADDR_W (COL_W)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (r_s1.valid),
        .i_waddr (r_s1.col),
        .i_wdata (wr_entry),
        .i_re    (take),
        .i_raddr (rd_addr),
        .o_rdata (ram_rdata)
    );

    // ---------------- stage 1: compute, write back, push result
    // r_cur holds the RAM word of this beat's column; the read data is the
    // word of the next column (right neighbour now, centre for the next beat)
    assign rd_entry  = r_s1.fwd ? r_fwd_data : ram_rdata;
    assign right_pix = r_s1.right_en ? rd_entry.centre : '0;
    assign above_pix = r_s1.above_en ? r_cur.above : '0;
    assign wr_entry.above  = r_cur.centre;
    assign wr_entry.centre = r_s1.below;

    lef_calc u_calc (
        .i_above  (above_pix),
        .i_below  (r_s1.below),
        .i_left   (r_left),
        .i_right  (right_pix),
        .i_centre (r_cur.centre),
        .o_result (lap_pix)
    );

    always_ff @(posedge i_clk) begin
        if (r_s1.valid) begin
            // one-pixel rows: the next beat's word is the one written now
            r_cur <= r_s1.self_fwd ? wr_entry : rd_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= '0;
        end else if (i_cfg_we) begin
            r_left <= '0;
        end else if (r_s1.valid) begin
            if (!r_s1.right_en) begin
                r_left <= '0;
            end else if (r_s1.emit) begin
                r_left <= r_cur.centre;
            end
        end
    end

    assign push               = r_s1.valid & r_s1.emit;
    assign push_data.pix      = lap_pix;
    assign push_data.frame_end = r_s1.frame_end;

    lef_out_fifo u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_data),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_data  (out_data),
        .o_count (out_count)
    );

    // credit check: queued results plus the one in flight must leave a slot
    assign o_in_ready = ((OUT_CNT_W + 1)'(out_count) + (OUT_CNT_W + 1)'(push))
                        < (OUT_CNT_W + 1)'(OUT_DEPTH);

    assign o_out_red   = out_data.pix.red;
    assign o_out_green = out_data.pix.green;
    assign o_out_blue  = out_data.pix.blue;
    assign o_frame_end = out_data.frame_end;

endmodule

FILE: sv/lef_line_ram.sv
// Simple dual-port line RAM, one write and one registered read per cycle.
// Read returns the old word on a same-address write. Standalone, no package.
module lef_line_ram #(
    parameter int DATA_W = 48,
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: sv/lef_calc.sv
// Per-channel four-neighbour Laplacian with clamp to 0..255.
// Depends on lef_pkg for the pixel type.
module lef_calc
    import lef_pkg::*;
(
    input  t_pixel i_above,
    input  t_pixel i_below,
    input  t_pixel i_left,
    input  t_pixel i_right,
    input  t_pixel i_centre,
    output t_pixel o_result
);

    localparam int SUM_W = CH_W + 4;

    function automatic logic [CH_W-1:0] lap(
        input logic [CH_W-1:0] u,
        input logic [CH_W-1:0] d,
        input logic [CH_W-1:0] l,
        input logic [CH_W-1:0] r,
        input logic [CH_W-1:0] c
    );
        logic [SUM_W-1:0] s;
        logic [CH_W-1:0]  y;
        s = SUM_W'(u) + SUM_W'(d) + SUM_W'(l) + SUM_W'(r) - {2'b00, c, 2'b00};
        if (s[SUM_W-1]) begin
            y = '0;
        end else if (|s[SUM_W-2:CH_W]) begin
            y = '1;
        end else begin
            y = s[CH_W-1:0];
        end
        return y;
    endfunction

    assign o_result.red   = lap(i_above.red, i_below.red, i_left.red,
                                i_right.red, i_centre.red);
    assign o_result.green = lap(i_above.green, i_below.green, i_left.green,
                                i_right.green, i_centre.green);
    assign o_result.blue  = lap(i_above.blue, i_below.blue, i_left.blue,
                                i_right.blue, i_centre.blue);

endmodule

FILE: sv/lef_out_fifo.sv
// Small result queue between the filter pipeline and the output channel.
// Depends on lef_pkg for depth and result type.
module lef_out_fifo
    import lef_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  t_result              i_data,
    output logic                 o_valid,
    input  logic                 i_ready,
    output t_result              o_data,
    output logic [OUT_CNT_W-1:0] o_count
);

    t_result              r_buf [OUT_DEPTH];
    logic [OUT_PTR_W-1:0] r_wr_ptr;
    logic [OUT_PTR_W-1:0] r_rd_ptr;
    logic [OUT_CNT_W-1:0] r_count;
    logic                 pop;

    assign pop = (r_count != '0) & i_ready;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_buf[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == OUT_PTR_W'(OUT_DEPTH - 1)) ? '0
                          : r_wr_ptr + OUT_PTR_W'(1);
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == OUT_PTR_W'(OUT_DEPTH - 1)) ? '0
                          : r_rd_ptr + OUT_PTR_W'(1);
            end
            case ({i_push, pop})
                2'b10:   r_count <= r_count + OUT_CNT_W'(1);
                2'b01:   r_count <= r_count - OUT_CNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    assign o_valid = (r_count != '0);
    assign o_data  = r_buf[r_rd_ptr];
    assign o_count = r_count;

endmodule

FILE: sv/lef_checker.sv
// Port-level checks for the RGB Laplacian edge filter, bound to the top level.
// Depends on lef_pkg for channel width.
module lef_checker
    import lef_pkg::*;
(
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            i_in_valid,
    input logic            i_in_ready,
    input logic            i_out_valid,
    input logic            i_out_ready,
    input logic [CH_W-1:0] i_out_red,
    input logic [CH_W-1:0] i_out_green,
    input logic [CH_W-1:0] i_out_blue,
    input logic            i_frame_end
);

    logic in_beat;

    assign in_beat = i_in_valid & i_in_ready;

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid &&
            $stable({i_out_red, i_out_green, i_out_blue, i_frame_end})))
        else $error("result beat changed while stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    // with nothing queued the credit check must leave room
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input stalled with empty output queue");

    // an idle input keeps an empty output empty
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!i_out_valid && !in_beat && !$past(in_beat)) |=> !i_out_valid)
        else $error("result appeared without an input beat");

endmodule

bind laplacian_edge_filter_rgb_top lef_checker u_lef_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .i_in_ready  (o_in_ready),
    .i_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .i_out_red   (o_out_red),
    .i_out_green (o_out_green),
    .i_out_blue  (o_out_blue),
    .i_frame_end (o_frame_end)
);
